@@ sv/nnue_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnue_pkg
// shared commands, register indexes, reset values and types for the
// incremental accumulator with relu dot-product output stage
// ----------------------------------------------------------------------------
package nnue_pkg;

    // command codes
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_SUB   = 3'd2;
    localparam logic [2:0] CMD_LOAD  = 3'd3;
    localparam logic [2:0] CMD_EVAL  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_BIAS_GAIN     = 2'd0;
    localparam logic [1:0] CFG_HEAD_BIAS     = 2'd1;
    localparam logic [1:0] CFG_HIDDEN_IN_USE = 2'd2;

    // field widths
    localparam int ACC_W   = 32;
    localparam int WGT_W   = 16;
    localparam int SCORE_W = 64;
    localparam int PROD_W  = ACC_W + WGT_W;
    localparam int SCALE_W = 31;
    localparam int BIAS_W  = 32;
    localparam int NUSE_W  = 9;
    localparam int UNIT_W  = 8;
    localparam int CFG_W   = 32;

    // register reset values
    localparam logic [SCALE_W-1:0] BIAS_GAIN_RST     = 31'd256;
    localparam logic [BIAS_W-1:0]  HEAD_BIAS_RST     = 32'd0;
    localparam logic [NUSE_W-1:0]  HIDDEN_IN_USE_RST = 9'd256;

    // one accumulator update as it enters the read-modify-write pipe
    typedef struct packed {
        logic                    valid;
        logic                    sub;
        logic signed [WGT_W-1:0] delta;
    } acc_upd_t;

endpackage
`default_nettype wire

@@ sv/nnue_acc_bank.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnue_acc_bank
// accumulator memory with read-modify-write update pipe, write forwarding
// and a clear write port
// ----------------------------------------------------------------------------
module nnue_acc_bank #(
    parameter int AW = 9
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nnue_pkg::acc_upd_t            upd,
    input  wire logic [AW-1:0]                 upd_addr,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    input  wire logic                          clr_en,
    input  wire logic [AW-1:0]                 clr_addr,
    output logic signed [nnue_pkg::ACC_W-1:0]  rd_data
);

    localparam int DEPTH = 2 ** AW;

    logic [nnue_pkg::ACC_W-1:0] acc_mem [0:DEPTH-1];

    logic [nnue_pkg::ACC_W-1:0] rd_data_reg;
    logic                       s1_valid_reg;
    logic                       s1_sub_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic [nnue_pkg::WGT_W-1:0] s1_delta_reg;
    logic                       fwd_hit_reg;
    logic                       fwd_hit_next;
    logic [nnue_pkg::ACC_W-1:0] fwd_data_reg;

    logic                       rd_fire;
    logic [AW-1:0]              rd_sel_addr;
    logic [nnue_pkg::ACC_W-1:0] old_val;
    logic [nnue_pkg::ACC_W-1:0] delta_ext;
    logic [nnue_pkg::ACC_W-1:0] new_val;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [nnue_pkg::ACC_W-1:0] wr_data;

    // update reads take the port over evaluation reads
    assign rd_fire     = upd.valid | rd_en;
    assign rd_sel_addr = upd.valid ? upd_addr : rd_addr;

    // newest value: forwarded when the previous write hit the same entry
    assign old_val   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign delta_ext = {{(nnue_pkg::ACC_W - nnue_pkg::WGT_W){s1_delta_reg[nnue_pkg::WGT_W-1]}},
                        s1_delta_reg};
    assign new_val   = s1_sub_reg ? (old_val - delta_ext) : (old_val + delta_ext);

    assign wr_en   = clr_en | s1_valid_reg;
    assign wr_addr = clr_en ? clr_addr : s1_addr_reg;
    assign wr_data = clr_en ? '0 : new_val;

    assign fwd_hit_next = upd.valid & wr_en & (wr_addr == upd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_mem[wr_addr] <= wr_data;
        end
        if (rd_fire)
        begin
            rd_data_reg <= acc_mem[rd_sel_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= upd.valid;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sub_reg   <= upd.sub;
        s1_addr_reg  <= upd_addr;
        s1_delta_reg <= upd.delta;
        fwd_data_reg <= wr_data;
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ sv/nnue_dot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnue_dot
// output weight memory and the relu multiply-accumulate walk over the
// hidden units of one side
// ----------------------------------------------------------------------------
module nnue_dot #(
    parameter int UW = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            eval_start,
    input  wire logic                            eval_side,
    input  wire logic [UW:0]                     eval_count,
    input  wire logic [nnue_pkg::SCALE_W-1:0]    bias_gain,
    input  wire logic signed [nnue_pkg::BIAS_W-1:0] head_bias,
    input  wire logic                            wgt_we,
    input  wire logic [UW:0]                     wgt_addr,
    input  wire logic [nnue_pkg::WGT_W-1:0]      wgt_data,
    output logic                                 acc_rd_en,
    output logic [UW:0]                          acc_rd_addr,
    input  wire logic signed [nnue_pkg::ACC_W-1:0] acc_rd_data,
    output logic                                 finish,
    output logic                                 score_valid,
    output logic [nnue_pkg::SCORE_W-1:0]         score
);

    localparam int DEPTH = 2 ** (UW + 1);
    localparam int EXT_W = nnue_pkg::SCORE_W - nnue_pkg::PROD_W;

    logic [nnue_pkg::WGT_W-1:0] wgt_mem [0:DEPTH-1];

    logic                               active_reg;
    logic                               side_reg;
    logic [UW:0]                        count_reg;
    logic [UW:0]                        idx_reg;
    logic                               rdv_reg;
    logic                               prodv_reg;
    logic signed [nnue_pkg::WGT_W-1:0]  wgt_rd_reg;
    logic signed [nnue_pkg::PROD_W-1:0] prod_reg;
    logic signed [nnue_pkg::PROD_W-1:0] prod_next;
    logic [nnue_pkg::SCORE_W-1:0]       sum_reg;
    logic signed [nnue_pkg::SCORE_W-1:0] bias_term;
    logic                               score_valid_reg;
    logic [nnue_pkg::SCORE_W-1:0]       score_reg;
    logic                               issue;
    logic                               relu_pos;

    assign issue       = active_reg & (idx_reg != count_reg);
    assign acc_rd_en   = issue;
    assign acc_rd_addr = {side_reg, idx_reg[UW-1:0]};
    assign finish      = active_reg & ~issue & ~rdv_reg & ~prodv_reg;

    // only strictly positive hidden units contribute
    assign relu_pos  = ~acc_rd_data[nnue_pkg::ACC_W-1] & (acc_rd_data != '0);
    assign prod_next = relu_pos ? ((nnue_pkg::PROD_W)'(acc_rd_data)
                                   * (nnue_pkg::PROD_W)'(wgt_rd_reg)) : '0;

    assign bias_term = (nnue_pkg::SCORE_W)'(head_bias)
                       * (nnue_pkg::SCORE_W)'($signed({1'b0, bias_gain}));

    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[wgt_addr] <= wgt_data;
        end
        if (issue)
        begin
            wgt_rd_reg <= wgt_mem[acc_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            idx_reg         <= '0;
            rdv_reg         <= 1'b0;
            prodv_reg       <= 1'b0;
            score_valid_reg <= 1'b0;
        end
        else
        begin
            rdv_reg         <= issue;
            prodv_reg       <= rdv_reg;
            score_valid_reg <= finish;
            if (eval_start)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (finish)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (eval_start)
        begin
            side_reg  <= eval_side;
            count_reg <= eval_count;
            sum_reg   <= bias_term;
        end
        else if (prodv_reg)
        begin
            sum_reg <= sum_reg + {{EXT_W{prod_reg[nnue_pkg::PROD_W-1]}}, prod_reg};
        end
        if (finish)
        begin
            score_reg <= sum_reg;
        end
    end

    assign score_valid = score_valid_reg;
    assign score       = score_reg;

endmodule
`default_nettype wire

@@ sv/nnue_accumulator_relu_dot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnue_accumulator_relu_dot
// two-sided incremental hidden accumulator with a relu dot-product
// evaluation against stored output weights
// ----------------------------------------------------------------------------
// Commands are taken on start while busy is low. Add, subtract and load
// output weight may follow one another in every cycle; an add or subtract
// is a read-modify-write on the accumulator memory, the old value read into
// a register and then written back with the delta applied, with forwarding
// so a back-to-back update of the same unit sees the newest value. Clear and
// the reset both run a clearing pass that writes one accumulator entry per
// cycle over all 2 * 2^max(1, clog2(HIDDEN)) entries (512 at HIDDEN = 256),
// with busy high; configuration writes are taken as ever during it. Evaluate
// walks the n = min(hidden_in_use, HIDDEN) units of one side through the
// single read port of each memory, one unit a cycle, then a multiply stage
// and an accumulate stage, with busy high throughout; score shows with
// score_valid for exactly one cycle right after. There is no back-pressure
// on the result: the receiver must take score in the cycle score_valid is
// high. Output weights read by an evaluate must have been loaded first.
// ----------------------------------------------------------------------------
module nnue_accumulator_relu_dot #(
    parameter int HIDDEN = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // command transfer
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [2:0]                          command,
    input  wire logic                                side,
    input  wire logic [nnue_pkg::UNIT_W-1:0]         unit,
    input  wire logic signed [nnue_pkg::WGT_W-1:0]   weight_value,
    // result transfer
    output logic                                     score_valid,
    output logic signed [nnue_pkg::SCORE_W-1:0]      score,
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [nnue_pkg::CFG_W-1:0]          cfg_data
);

    // unit index width, side bit on top gives the memory address
    localparam int UW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int AW = UW + 1;
    localparam int CW = (UW > nnue_pkg::UNIT_W) ? UW : nnue_pkg::UNIT_W;

    // control states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [AW-1:0]                       clr_cnt_reg;

    logic [nnue_pkg::SCALE_W-1:0]        bias_gain_reg;
    logic signed [nnue_pkg::BIAS_W-1:0]  head_bias_reg;
    logic [nnue_pkg::NUSE_W-1:0]         hidden_in_use_reg;

    logic                                accept;
    logic                                unit_ok;
    logic [CW-1:0]                       unit_w;
    logic [AW-1:0]                       item_addr;
    logic                                do_clear;
    logic                                do_eval;
    logic                                do_load;
    nnue_pkg::acc_upd_t                  upd;
    logic [UW:0]                         eval_count;

    logic                                acc_rd_en;
    logic [AW-1:0]                       acc_rd_addr;
    logic signed [nnue_pkg::ACC_W-1:0]   acc_rd_data;
    logic                                clr_en;
    logic                                dot_finish;
    logic                                dot_valid;
    logic [nnue_pkg::SCORE_W-1:0]        dot_score;

    // ---------------------------------------------------------------- decode
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start & ~busy;
    assign unit_w  = CW'(unit);
    assign unit_ok = (32'(unit) < 32'(HIDDEN));
    assign item_addr = {side, unit_w[UW-1:0]};

    always_comb
    begin
        do_clear  = 1'b0;
        do_eval   = 1'b0;
        do_load   = 1'b0;
        upd.valid = 1'b0;
        upd.sub   = 1'b0;
        upd.delta = weight_value;
        if (accept)
        begin
            unique case (command)
                nnue_pkg::CMD_CLEAR: do_clear = 1'b1;
                nnue_pkg::CMD_ADD:   upd.valid = unit_ok;
                nnue_pkg::CMD_SUB:
                begin
                    upd.valid = unit_ok;
                    upd.sub   = 1'b1;
                end
                nnue_pkg::CMD_LOAD:  do_load = unit_ok;
                nnue_pkg::CMD_EVAL:  do_eval = 1'b1;
                default:             ; // unused codes are dropped
            endcase
        end
    end

    // units summed, saturated at the vector length
    assign eval_count = (32'(hidden_in_use_reg) > 32'(HIDDEN)) ? (UW + 1)'(HIDDEN)
                                                              : (UW + 1)'(hidden_in_use_reg);

    // ---------------------------------------------------------- control fsm
    assign clr_en = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_clear)
                begin
                    state_next = ST_CLEAR;
                end
                else if (do_eval)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                if (dot_finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // reset lands in the clearing pass so the accumulators start at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------ config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_gain_reg     <= nnue_pkg::BIAS_GAIN_RST;
            head_bias_reg     <= nnue_pkg::HEAD_BIAS_RST;
            hidden_in_use_reg <= nnue_pkg::HIDDEN_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nnue_pkg::CFG_BIAS_GAIN:
                    bias_gain_reg     <= cfg_data[nnue_pkg::SCALE_W-1:0];
                nnue_pkg::CFG_HEAD_BIAS:
                    head_bias_reg     <= cfg_data[nnue_pkg::BIAS_W-1:0];
                nnue_pkg::CFG_HIDDEN_IN_USE:
                    hidden_in_use_reg <= cfg_data[nnue_pkg::NUSE_W-1:0];
                default: ; // index past the register list is ignored
            endcase
        end
    end

    // ------------------------------------------------------------- datapath
    nnue_acc_bank #(
        .AW (AW)
    ) u_acc_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .upd_addr (item_addr),
        .rd_en    (acc_rd_en),
        .rd_addr  (acc_rd_addr),
        .clr_en   (clr_en),
        .clr_addr (clr_cnt_reg),
        .rd_data  (acc_rd_data)
    );

    nnue_dot #(
        .UW (UW)
    ) u_dot (
        .clk           (clk),
        .rst_n         (rst_n),
        .eval_start    (do_eval),
        .eval_side     (side),
        .eval_count    (eval_count),
        .bias_gain     (bias_gain_reg),
        .head_bias     (head_bias_reg),
        .wgt_we        (do_load),
        .wgt_addr      (item_addr),
        .wgt_data      (weight_value),
        .acc_rd_en     (acc_rd_en),
        .acc_rd_addr   (acc_rd_addr),
        .acc_rd_data   (acc_rd_data),
        .finish        (dot_finish),
        .score_valid   (dot_valid),
        .score         (dot_score)
    );

    assign score_valid = dot_valid;
    assign score       = dot_score;

    // ------------------------------------------------------------ assertions
    // a result only ever follows an evaluation walk
    a_score_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid |-> $past(state_reg == ST_EVAL))
        else $error("score strobe without an evaluation in progress");

    // the result strobe never lasts more than one transfer
    a_score_single: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid |=> !score_valid)
        else $error("score strobe held for more than one cycle");

    // the clearing pass owns the accumulator memory alone
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        clr_en |-> (!acc_rd_en && !upd.valid))
        else $error("accumulator access during the clearing pass");

    // an accepted evaluate keeps the block busy in the next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        do_eval |=> (busy && !score_valid))
        else $error("evaluation did not hold the block busy");

endmodule
`default_nettype wire

@@ tb/sv/tb_nnue_accumulator_relu_dot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nnue_accumulator_relu_dot
// self-checking bench for the two-sided hidden accumulator with relu dot
// output. A table of directed commands runs first, then every output weight
// is loaded, then six phases of random command streams under different
// register settings. Every accepted command goes through a local model of
// the block, and each score strobe is checked against the oldest outstanding
// evaluate in order.
// ----------------------------------------------------------------------------
module tb_nnue_accumulator_relu_dot;

    localparam int HIDDEN_UNITS = 256;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 35;
    localparam int PLAN_ROWS    = 32;

    // command codes the block must ignore
    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    // register index with nothing behind it
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    // ------------------------------------------------------------------------
    // clock, reset and block ports, the inputs all at known values from time zero
    // ------------------------------------------------------------------------
    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               start        = 1'b0;
    logic                               busy;
    logic [2:0]                         command      = nnue_pkg::CMD_CLEAR;
    logic                               side         = 1'b0;
    logic [nnue_pkg::UNIT_W-1:0]        unit         = '0;
    logic signed [nnue_pkg::WGT_W-1:0]  weight_value = '0;
    logic                               score_valid;
    logic signed [nnue_pkg::SCORE_W-1:0] score;
    logic                               cfg_we       = 1'b0;
    logic [1:0]                         cfg_index    = nnue_pkg::CFG_BIAS_GAIN;
    logic [nnue_pkg::CFG_W-1:0]         cfg_data     = '0;

    always #6 clk = ~clk;

    nnue_accumulator_relu_dot #(
        .HIDDEN (HIDDEN_UNITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .side         (side),
        .unit         (unit),
        .weight_value (weight_value),
        .score_valid  (score_valid),
        .score        (score),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // local copy of the block state
    // ------------------------------------------------------------------------
    logic [nnue_pkg::ACC_W-1:0]        hidden_acc [2][HIDDEN_UNITS];
    logic signed [nnue_pkg::WGT_W-1:0] out_wgt    [2][HIDDEN_UNITS];
    logic [nnue_pkg::SCALE_W-1:0]      cur_scale;
    logic [nnue_pkg::BIAS_W-1:0]       cur_bias;
    logic [nnue_pkg::NUSE_W-1:0]       cur_nuse;

    // scores still owed by the block, oldest first
    logic [nnue_pkg::SCORE_W-1:0] pending_scores [$];

    int mismatches     = 0;
    int commands_sent  = 0;
    int scores_checked = 0;
    int cycles         = 0;
    int idle_pct       = 0;

    // ------------------------------------------------------------------------
    // directed table: register writes and commands in order; a score is typed
    // in only where it is plain from the register values, the rest go to the
    // model
    // ------------------------------------------------------------------------
    typedef struct {
        bit                          is_write;
        logic [1:0]                  reg_index;
        logic [nnue_pkg::CFG_W-1:0]  reg_data;
        logic [2:0]                  op;
        logic                        sd;
        logic [nnue_pkg::UNIT_W-1:0] un;
        logic [nnue_pkg::WGT_W-1:0]  wv;
        bit                          has_score;
        logic [nnue_pkg::SCORE_W-1:0] score_lit;
    } plan_row_t;

    plan_row_t plan [PLAN_ROWS] = '{
        // no units summed, unmapped register write must not land anywhere
        '{1'b1, nnue_pkg::CFG_HIDDEN_IN_USE, 32'h0000_0000, nnue_pkg::CMD_CLEAR,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        '{1'b1, CFG_UNMAPPED, 32'hFFFF_FFFF, nnue_pkg::CMD_CLEAR,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_EVAL,
          1'b0, 8'h00, 16'h0000, 1'b1, 64'h0},
        // bias term alone at both extremes
        '{1'b1, nnue_pkg::CFG_BIAS_GAIN, 32'h7FFF_FFFF, nnue_pkg::CMD_CLEAR,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        '{1'b1, nnue_pkg::CFG_HEAD_BIAS, 32'h8000_0000, nnue_pkg::CMD_CLEAR,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_EVAL,
          1'b1, 8'hFF, 16'hFFFF, 1'b1, 64'hC000_0000_8000_0000},
        '{1'b1, nnue_pkg::CFG_HEAD_BIAS, 32'h7FFF_FFFF, nnue_pkg::CMD_CLEAR,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_EVAL,
          1'b0, 8'h00, 16'h0000, 1'b1, 64'h3FFF_FFFF_0000_0001},
        // unused commands, no score and no state change
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, CMD_SPARE5,
          1'b1, 8'hFF, 16'h7FFF, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, CMD_SPARE6,
          1'b0, 8'h00, 16'h8000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, CMD_SPARE7,
          1'b1, 8'hAA, 16'h5555, 1'b0, 64'h0},
        // four units, unit scale, no bias
        '{1'b1, nnue_pkg::CFG_BIAS_GAIN, 32'h0000_0001, nnue_pkg::CMD_CLEAR,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        '{1'b1, nnue_pkg::CFG_HEAD_BIAS, 32'h0000_0000, nnue_pkg::CMD_CLEAR,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        '{1'b1, nnue_pkg::CFG_HIDDEN_IN_USE, 32'h0000_0004, nnue_pkg::CMD_CLEAR,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        // output weights at the extremes for both sides
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_LOAD,
          1'b0, 8'h00, 16'h7FFF, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_LOAD,
          1'b0, 8'h01, 16'h8000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_LOAD,
          1'b0, 8'h02, 16'h0001, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_LOAD,
          1'b0, 8'h03, 16'hFFFF, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_LOAD,
          1'b1, 8'h00, 16'h8000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_LOAD,
          1'b1, 8'h01, 16'h7FFF, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_LOAD,
          1'b1, 8'h02, 16'hFFFF, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_LOAD,
          1'b1, 8'h03, 16'h0001, 1'b0, 64'h0},
        // updates back to back, one unit per side left negative so relu drops it
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_ADD,
          1'b0, 8'h00, 16'h7FFF, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_ADD,
          1'b0, 8'h01, 16'h7FFF, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_SUB,
          1'b0, 8'h02, 16'h8000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_SUB,
          1'b0, 8'h03, 16'h0005, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_ADD,
          1'b1, 8'h00, 16'h8000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_ADD,
          1'b1, 8'h01, 16'h0064, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_EVAL,
          1'b0, 8'h00, 16'h0000, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_EVAL,
          1'b1, 8'h00, 16'h0000, 1'b0, 64'h0},
        // clear wipes both sides
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_CLEAR,
          1'b1, 8'hFF, 16'hFFFF, 1'b0, 64'h0},
        '{1'b0, nnue_pkg::CFG_BIAS_GAIN, 32'h0, nnue_pkg::CMD_EVAL,
          1'b0, 8'h00, 16'h0000, 1'b1, 64'h0}
    };

    // ------------------------------------------------------------------------
    // model of the evaluate: bias times scale plus the relu dot product over
    // the units in use, all in 64-bit wrapping arithmetic
    // ------------------------------------------------------------------------
    function automatic logic [nnue_pkg::SCORE_W-1:0] relu_dot(input logic sd);
        int     n;
        int     u;
        longint total;
        longint h;
        n = (cur_nuse > HIDDEN_UNITS) ? HIDDEN_UNITS : int'(cur_nuse);
        total = longint'($signed(cur_bias)) * longint'(cur_scale);
        for (u = 0; u < n; u++) begin
            h = longint'($signed(hidden_acc[sd][u]));
            if (h > 0)
                total += h * longint'(out_wgt[sd][u]);
        end
        return total;
    endfunction

    // applies one accepted command to the model, returns the score it owes
    function automatic logic [nnue_pkg::SCORE_W-1:0] apply_command(
        input logic [2:0]                        op,
        input logic                              sd,
        input logic [nnue_pkg::UNIT_W-1:0]       un,
        input logic signed [nnue_pkg::WGT_W-1:0] wv
    );
        logic [nnue_pkg::ACC_W-1:0] delta;
        delta = {{(nnue_pkg::ACC_W-nnue_pkg::WGT_W){wv[nnue_pkg::WGT_W-1]}}, wv};
        case (op)
            nnue_pkg::CMD_CLEAR:
                foreach (hidden_acc[s, u])
                    hidden_acc[s][u] = '0;
            nnue_pkg::CMD_ADD:
                if (un < HIDDEN_UNITS)
                    hidden_acc[sd][un] = hidden_acc[sd][un] + delta;
            nnue_pkg::CMD_SUB:
                if (un < HIDDEN_UNITS)
                    hidden_acc[sd][un] = hidden_acc[sd][un] - delta;
            nnue_pkg::CMD_LOAD:
                if (un < HIDDEN_UNITS)
                    out_wgt[sd][un] = wv;
            nnue_pkg::CMD_EVAL:
                return relu_dot(sd);
            default: ;
        endcase
        return '0;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one register write; leaves the enable high so writes can run back to
    // back, the next command transfer or drain lowers it
    task automatic write_reg(input logic [1:0] idx, input logic [nnue_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            nnue_pkg::CFG_BIAS_GAIN:     cur_scale = data[nnue_pkg::SCALE_W-1:0];
            nnue_pkg::CFG_HEAD_BIAS:     cur_bias  = data[nnue_pkg::BIAS_W-1:0];
            nnue_pkg::CFG_HIDDEN_IN_USE: cur_nuse  = data[nnue_pkg::NUSE_W-1:0];
            default: ;
        endcase
    endtask

    // waits until every score is in and the block has gone idle, which also
    // covers a clearing pass that owes no score
    task automatic drain();
        start  <= 1'b0;
        cfg_we <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_config(
        input logic [nnue_pkg::CFG_W-1:0] scale_data,
        input logic [nnue_pkg::CFG_W-1:0] bias_data,
        input logic [nnue_pkg::CFG_W-1:0] nuse_data
    );
        drain();
        write_reg(nnue_pkg::CFG_BIAS_GAIN, scale_data);
        write_reg(nnue_pkg::CFG_HEAD_BIAS, bias_data);
        write_reg(nnue_pkg::CFG_HIDDEN_IN_USE, nuse_data);
    endtask

    // one command transfer, with an optional idle burst first; start stays
    // high between back-to-back transfers
    task automatic issue(
        input logic [2:0]                        op,
        input logic                              sd,
        input logic [nnue_pkg::UNIT_W-1:0]       un,
        input logic signed [nnue_pkg::WGT_W-1:0] wv,
        input bit                                has_score,
        input logic [nnue_pkg::SCORE_W-1:0]      score_lit
    );
        logic [nnue_pkg::SCORE_W-1:0] predicted;
        cfg_we <= 1'b0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        start        <= 1'b1;
        command      <= op;
        side         <= sd;
        unit         <= un;
        weight_value <= wv;
        @(posedge clk);
        // busy as sampled by this edge decides the transfer
        while (busy)
            @(posedge clk);
        predicted = apply_command(op, sd, un, wv);
        commands_sent++;
        if (op == nnue_pkg::CMD_EVAL)
            pending_scores.push_back(has_score ? score_lit : predicted);
    endtask

    // ------------------------------------------------------------------------
    // score checker: the receiver has no way to stall, every strobe counts
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_scores
        logic [nnue_pkg::SCORE_W-1:0] want;
        if (rst_n && score_valid) begin
            if (pending_scores.size() == 0) begin
                $display("%0t: score %0d (%h) with no evaluate outstanding",
                         $time, score, score);
                mismatches++;
            end else begin
                want = pending_scores.pop_front();
                scores_checked++;
                if (score !== want) begin
                    $display("%0t: score mismatch, expected %0d (%h), got %0d (%h)",
                             $time, $signed(want), want, score, score);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                                row;
        int                                p;
        int                                i;
        int                                s;
        int                                u;
        int                                pick;
        logic [31:0]                       rnd;
        logic [2:0]                        op;
        logic                              sd;
        logic [nnue_pkg::UNIT_W-1:0]       un;
        logic signed [nnue_pkg::WGT_W-1:0] wv;

        // model state after reset; unloaded weights are never read
        foreach (hidden_acc[s, u]) begin
            hidden_acc[s][u] = '0;
            out_wgt[s][u]    = '0;
        end
        cur_scale = nnue_pkg::BIAS_GAIN_RST;
        cur_bias  = nnue_pkg::HEAD_BIAS_RST;
        cur_nuse  = nnue_pkg::HIDDEN_IN_USE_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // the block clears itself after reset with busy high
        drain();

        // directed table, light idling
        idle_pct = 25;
        for (row = 0; row < PLAN_ROWS; row++) begin
            if (plan[row].is_write) begin
                drain();
                write_reg(plan[row].reg_index, plan[row].reg_data);
            end else begin
                issue(plan[row].op, plan[row].sd, plan[row].un, plan[row].wv,
                      plan[row].has_score, plan[row].score_lit);
            end
        end

        // load every output weight on both sides so that any later evaluate
        // reads only loaded entries
        for (s = 0; s < 2; s++) begin
            for (u = 0; u < HIDDEN_UNITS; u++) begin
                rnd  = $urandom;
                pick = $urandom_range(0, 9);
                wv   = (pick == 0) ? 16'sh7FFF : (pick == 1) ? 16'sh8000 : rnd[15:0];
                issue(nnue_pkg::CMD_LOAD, s[0], u[nnue_pkg::UNIT_W-1:0], wv, 1'b0, '0);
            end
        end

        // random phases, one register setting each; upper data bits are left
        // random in some phases so the register masking is exercised
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(32'd256, $urandom, 32'd256);
                1: set_config(32'd1, 32'h8000_0000, 32'd1);
                2: set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_01FF);
                3: set_config($urandom, $urandom, $urandom);
                4: set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd256);
                default: set_config($urandom, $urandom, $urandom_range(1, 300));
            endcase
            // one phase in the middle and the last one run flat out
            idle_pct = (p == 2 || p == PHASES - 1) ? 0 : 30;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    op = nnue_pkg::CMD_CLEAR;
                else if (pick < 45)
                    op = nnue_pkg::CMD_ADD;
                else if (pick < 62)
                    op = nnue_pkg::CMD_SUB;
                else if (pick < 72)
                    op = nnue_pkg::CMD_LOAD;
                else if (pick < 95)
                    op = nnue_pkg::CMD_EVAL;
                else if (pick < 97)
                    op = CMD_SPARE5;
                else if (pick < 99)
                    op = CMD_SPARE6;
                else
                    op = CMD_SPARE7;
                // half the updates land on the low units so that small unit
                // counts still see live accumulators
                rnd = $urandom;
                sd  = rnd[30];
                un  = rnd[31] ? {5'd0, rnd[2:0]} : rnd[7:0];
                rnd  = $urandom;
                pick = $urandom_range(0, 9);
                wv   = (pick == 0) ? 16'sh7FFF : (pick == 1) ? 16'sh8000 : rnd[15:0];
                issue(op, sd, un, wv, 1'b0, '0);
            end
        end

        // let every score come home, then watch for strays for a full walk
        drain();
        repeat (HIDDEN_UNITS + 8) @(posedge clk);

        $display("run covered %0d command transfers and %0d checked scores in %0d cycles,",
                 commands_sent, scores_checked, cycles);
        $display("directed extremes plus %0d random register settings", PHASES);
        if (mismatches == 0 && pending_scores.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
